// ----- sv/sliding_window_percentile_defines.svh -----
// ---------------------------------------------------------------------------
// Sliding window percentile assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_PERCENTILE_DEFINES_SVH
`define SLIDING_WINDOW_PERCENTILE_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SWP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sliding_window_percentile assertion failed");
// Implication: when the condition holds, the outcome follows in the next cycle.
`define SWP_ASSERT_NEXT(label, cond, outcome) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (outcome)) \
    else $error("sliding_window_percentile assertion failed");
`else
`define SWP_ASSERT(label, prop)
`define SWP_ASSERT_NEXT(label, cond, outcome)
`endif

`endif

// ----- sv/swp_pkg.sv -----
// ---------------------------------------------------------------------------
// Sliding window percentile package
// Sizes, types and register codes shared by the filter and its interfaces.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package swp_pkg;

  localparam int WINDOW_SIZE  = 64;
  localparam int SAMPLE_WIDTH = 16;

  localparam int SLOT_W     = $clog2(WINDOW_SIZE);
  localparam int CNT_W      = $clog2(WINDOW_SIZE + 1);
  localparam int BIT_W      = $clog2(SAMPLE_WIDTH);
  localparam int RANK_W     = 7;
  localparam int CFG_DATA_W = (RANK_W > SAMPLE_WIDTH) ? RANK_W : SAMPLE_WIDTH;

  localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(32);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_RANK = 1'b0,
    CFG_FILL = 1'b1
  } cfg_reg_t;

endpackage

// ----- sv/swp_in_if.sv -----
// ---------------------------------------------------------------------------
// Sliding window percentile sample channel
// Valid/ready channel carrying one sample per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swp_in_if;
  logic             valid;
  logic             ready;
  swp_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- sv/swp_out_if.sv -----
// ---------------------------------------------------------------------------
// Sliding window percentile result channel
// Valid/ready channel carrying the selected value and the window status.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swp_out_if;
  logic             valid;
  logic             ready;
  swp_pkg::sample_t percentile_value;
  logic             window_full;

  modport source (output valid, output percentile_value, output window_full, input ready);
  modport sink   (input valid, input percentile_value, input window_full, output ready);
endinterface

// ----- sv/sliding_window_percentile.sv -----
// ---------------------------------------------------------------------------
// Sliding window percentile filter
// Rank-order filter over the last WINDOW_SIZE samples, one compare unit.
// ---------------------------------------------------------------------------
// Usage: each item on the samples channel overwrites the oldest slot of a
// circular window, and one item on the results channel follows with the
// rank_select-th smallest value in the window and a flag that is set once
// every slot holds a real sample. Slots not yet written count as fill_value.
// Both registers are written through the cfg port; the user must write them
// only while the block is idle, which the block itself does not enforce.
// The result is found by a bitwise search from the MSB: for each bit, one
// comparator sweeps the window memory (one slot per cycle, registered read)
// and counts the slots at or below a trial threshold.
// The search time is set by the sweep of the single memory read port. One item
// is in work at a time: the samples channel is ready only while the sequencer
// is idle.
// The next item is accepted while the previous result is still held in the
// output register; a stalled receiver only holds up the loading of the next
// result. Reset empties the window, returns rank_select to 32 and fill_value
// to 0, and leaves the memory contents as they are (unwritten slots read as
// fill_value through the sample count).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_percentile_defines.svh"

module sliding_window_percentile (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  swp_pkg::cfg_reg_t                    cfg_index,
  input  logic [swp_pkg::CFG_DATA_W-1:0]       cfg_data,
  swp_in_if.sink                               samples,
  swp_out_if.source                            results
);

  localparam int SW = swp_pkg::SAMPLE_WIDTH;
  localparam int W  = swp_pkg::WINDOW_SIZE;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // Configuration registers.
  logic [swp_pkg::RANK_W-1:0] rank_select;
  swp_pkg::sample_t           fill_value;

  // Window storage and its bookkeeping.
  logic [SW-1:0]              window_store [W];
  logic [swp_pkg::SLOT_W-1:0] oldest_slot;
  logic [swp_pkg::CNT_W-1:0]  samples_seen;

  // Sequencer.
  state_t                     state;
  logic [swp_pkg::SLOT_W-1:0] scan_addr;
  logic [swp_pkg::BIT_W-1:0]  bit_idx;
  logic [SW-1:0]              prefix;     // decided result bits, offset-binary
  logic [swp_pkg::CNT_W-1:0]  cnt_acc;
  logic [swp_pkg::CNT_W-1:0]  rank_eff;

  // Registered memory read.
  logic [SW-1:0]              rd_data;
  logic [swp_pkg::SLOT_W-1:0] rd_slot;
  logic                       rd_vld;

  // Output register.
  logic                       out_valid;
  swp_pkg::sample_t           out_value;
  logic                       out_full;

  logic                       accept;
  logic                       out_load;
  logic                       window_full;
  logic [SW-1:0]              elem;
  logic [SW-1:0]              elem_u;
  logic [SW-1:0]              trial;
  logic                       hit;
  logic [swp_pkg::CNT_W-1:0]  cnt_fin;
  logic [swp_pkg::CNT_W-1:0]  rank_clamped;

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign out_load      = (state == S_DONE) && (!out_valid || results.ready);
  assign window_full   = (samples_seen == swp_pkg::CNT_W'(W));

  assign results.valid            = out_valid;
  assign results.percentile_value = out_value;
  assign results.window_full      = out_full;

  // Rank zero selects the minimum; a rank beyond the window selects the maximum.
  always_comb begin
    if (rank_select == '0) begin
      rank_clamped = swp_pkg::CNT_W'(1);
    end else if (32'(rank_select) > 32'(W)) begin
      rank_clamped = swp_pkg::CNT_W'(W);
    end else begin
      rank_clamped = swp_pkg::CNT_W'(rank_select);
    end
  end

  // Compare unit: slots past the sample count read as the fill value. Values are
  // compared in offset binary so that an unsigned compare orders signed samples.
  always_comb begin
    if (swp_pkg::CNT_W'(rd_slot) < samples_seen) begin
      elem = rd_data;
    end else begin
      elem = fill_value;
    end
    elem_u  = {~elem[SW-1], elem[SW-2:0]};
    trial   = prefix | ~({SW{1'b1}} << bit_idx);
    hit     = rd_vld && (elem_u <= trial);
    cnt_fin = cnt_acc + swp_pkg::CNT_W'(hit);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_select <= swp_pkg::RANK_RESET;
      fill_value  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        swp_pkg::CFG_RANK: rank_select <= cfg_data[swp_pkg::RANK_W-1:0];
        swp_pkg::CFG_FILL: fill_value  <= cfg_data[SW-1:0];
        default:           rank_select <= rank_select;
      endcase
    end
  end

  // Window memory: one write on accept, one registered read per sweep cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      window_store[oldest_slot] <= samples.sample;
    end
    rd_data <= window_store[scan_addr];
    rd_slot <= scan_addr;
  end

  // Sequencer and search state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      oldest_slot  <= '0;
      samples_seen <= '0;
      scan_addr    <= '0;
      bit_idx      <= '0;
      cnt_acc      <= '0;
      rd_vld       <= 1'b0;
    end else begin
      rd_vld <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            oldest_slot <= (oldest_slot == swp_pkg::SLOT_W'(W - 1)) ? '0 : oldest_slot + 1'b1;
            if (!window_full) begin
              samples_seen <= samples_seen + 1'b1;
            end
            rank_eff  <= rank_clamped;
            prefix    <= '0;
            bit_idx   <= swp_pkg::BIT_W'(SW - 1);
            scan_addr <= '0;
            cnt_acc   <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld  <= 1'b1;
          cnt_acc <= cnt_fin;
          if (scan_addr == swp_pkg::SLOT_W'(W - 1)) begin
            scan_addr <= '0;
            state     <= S_LAST;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        S_LAST: begin
          // Too few slots at or below the trial: the result has this bit set.
          if (cnt_fin < rank_eff) begin
            prefix <= prefix | (SW'(1) << bit_idx);
          end
          cnt_acc <= '0;
          if (bit_idx == '0) begin
            state <= S_DONE;
          end else begin
            bit_idx <= bit_idx - 1'b1;
            state   <= S_SCAN;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= {~prefix[SW-1], prefix[SW-2:0]};
      out_full  <= window_full;
    end
  end

  `SWP_ASSERT(a_seen_bounded, samples_seen <= swp_pkg::CNT_W'(W))
  `SWP_ASSERT(a_count_bounded, cnt_acc <= swp_pkg::CNT_W'(W))
  `SWP_ASSERT_NEXT(a_accept_starts_search, accept, state == S_SCAN && prefix == '0)
  `SWP_ASSERT_NEXT(a_accept_top_bit, accept, bit_idx == swp_pkg::BIT_W'(SW - 1))
  `SWP_ASSERT_NEXT(a_load_full_flag, out_load, out_valid && out_full == window_full)

endmodule
